// ===== rtl/core/lpfr_pkg.sv =====
// Shared types and constants of the length-prefixed frame receiver.
package lpfr_pkg;

    localparam int MAX_PAYLOAD    = 1024;
    localparam int CHECKSUM_BYTES = 4;
    localparam int LEN_BYTES      = 4;

    localparam int BUF_AW = $clog2(MAX_PAYLOAD);
    localparam int CHK_W  = $clog2(CHECKSUM_BYTES + 1);

    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 10;
    localparam int FLEN_W    = 10;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_ACCEPT = 3'd1,
        EV_BADLEN = 3'd2,
        EV_BADEND = 3'd3,
        EV_READ   = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        REG_START_FIRST  = 2'd0,
        REG_START_SECOND = 2'd1,
        REG_END_FIRST    = 2'd2,
        REG_END_SECOND   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [BYTE_W-1:0] end_first;
        logic [BYTE_W-1:0] end_second;
    } marks_t;

    typedef struct packed {
        event_t            ev;
        logic [FLEN_W-1:0] flen;
    } evt_t;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } buf_wr_t;

endpackage

// ===== rtl/core/length_prefixed_frame_receiver.sv =====
// Top level of the length-prefixed frame receiver.
//
// Usage: the slave stream carries one request per transaction. With s_tuser low the
// transaction is a received link byte; with s_tuser high it is a read of one stored
// payload byte. Link bytes drive a frame state machine that hunts for the two-byte
// start marker, gathers a 4-byte big-endian length, stores the payload in a
// 1024-byte buffer, skips the checksum bytes and checks the two-byte end marker.
// Every request transaction produces exactly one result transaction on the master
// stream; m_tuser gives the event code and m_tdata the read byte and frame length.
// The user must write the marker bytes over the APB port only while the stream is
// idle; the block does not enforce this. A result passes the middle stage and the
// output register. Throughput: one request per cycle while the master side does not
// stall, limited by the single buffer port pair (one write, one read per cycle).
// Reset clears the state machine, the pipeline and the marker registers; buffer
// contents are undefined until written by a frame. When the master side stalls the
// output register holds its result, the middle stage fills, and s_tready then drops
// until the stall clears; no result is lost or repeated.
module length_prefixed_frame_receiver (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lpfr_pkg::S_TDATA_W-1:0] s_tdata,  // rx_byte[7:0], read_index[17:8]
    input  logic                           s_tuser,  // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lpfr_pkg::M_TDATA_W-1:0] m_tdata,  // read_data[7:0], frame_length[17:8]
    output logic [2:0]                     m_tuser,  // event_res
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpfr_pkg::APB_AW-1:0]    paddr,
    input  logic [lpfr_pkg::APB_DW-1:0]    pwdata,
    output logic [lpfr_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import lpfr_pkg::*;

    marks_t            marks;
    evt_t              evt;
    buf_wr_t           wr;
    logic [BYTE_W-1:0] rdata;
    logic              in_acc;
    logic              rd_req;
    logic              rd_ok;
    logic [INDEX_W-1:0] rd_index;

    // Middle stage: lines up with the registered buffer read data.
    logic              s1_valid_reg, s1_valid_next;
    evt_t              s1_evt_reg, s1_evt_next;
    logic              s1_rdok_reg, s1_rdok_next;
    logic              s1_adv;

    // Output register.
    logic              o_valid_reg, o_valid_next;
    evt_t              o_evt_reg, o_evt_next;
    logic [BYTE_W-1:0] o_data_reg, o_data_next;

    assign in_acc   = s_tvalid && s_tready;
    assign rd_req   = in_acc && s_tuser;
    assign rd_index = s_tdata[BYTE_W +: INDEX_W];
    assign rd_ok    = 32'(rd_index) < 32'(MAX_PAYLOAD);

    assign s1_adv   = s1_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;

    lpfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .marks   (marks)
    );

    lpfr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (in_acc && !s_tuser),
        .rx_byte (s_tdata[BYTE_W-1:0]),
        .marks   (marks),
        .evt     (evt),
        .wr      (wr)
    );

    // A read and a write never share a cycle, and a write lands before any
    // later read is issued, so the buffer needs no forwarding.
    lpfr_buf u_buf (
        .clk   (clk),
        .wr    (wr),
        .re    (rd_req),
        .raddr (rd_index[BUF_AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_evt_next   = s1_evt_reg;
        s1_rdok_next  = s1_rdok_reg;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
            s1_rdok_next  = rd_ok;
            if (s_tuser)
            begin
                s1_evt_next.ev   = EV_READ;
                s1_evt_next.flen = '0;
            end
            else
            begin
                s1_evt_next = evt;
            end
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_evt_next   = o_evt_reg;
        o_data_next  = o_data_reg;
        if (m_tready)
        begin
            o_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            o_valid_next = 1'b1;
            o_evt_next   = s1_evt_reg;
            o_data_next  = (s1_evt_reg.ev == EV_READ && s1_rdok_reg) ? rdata : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_evt_reg  <= s1_evt_next;
        s1_rdok_reg <= s1_rdok_next;
        o_evt_reg   <= o_evt_next;
        o_data_reg  <= o_data_next;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_evt_reg.ev;
    assign m_tdata  = M_TDATA_W'({o_evt_reg.flen, o_data_reg});

endmodule

// ===== rtl/core/lpfr_regs.sv =====
// APB register file holding the start and end marker bytes.
module lpfr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpfr_pkg::APB_AW-1:0] paddr,
    input  logic [lpfr_pkg::APB_DW-1:0] pwdata,
    output logic [lpfr_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output lpfr_pkg::marks_t            marks
);
    import lpfr_pkg::*;

    marks_t   marks_reg;
    marks_t   marks_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign marks  = marks_reg;

    always_comb
    begin
        marks_next = marks_reg;
        if (wr_en)
        begin
            case (idx)
                REG_START_FIRST:  marks_next.start_first  = pwdata[BYTE_W-1:0];
                REG_START_SECOND: marks_next.start_second = pwdata[BYTE_W-1:0];
                REG_END_FIRST:    marks_next.end_first    = pwdata[BYTE_W-1:0];
                REG_END_SECOND:   marks_next.end_second   = pwdata[BYTE_W-1:0];
                default:          marks_next = marks_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_FIRST:  prdata = APB_DW'(marks_reg.start_first);
            REG_START_SECOND: prdata = APB_DW'(marks_reg.start_second);
            REG_END_FIRST:    prdata = APB_DW'(marks_reg.end_first);
            REG_END_SECOND:   prdata = APB_DW'(marks_reg.end_second);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

endmodule

// ===== rtl/core/lpfr_buf.sv =====
// Payload buffer: one write port, one registered read port.
module lpfr_buf (
    input  logic                        clk,
    input  lpfr_pkg::buf_wr_t           wr,
    input  logic                        re,
    input  logic [lpfr_pkg::BUF_AW-1:0] raddr,
    output logic [lpfr_pkg::BYTE_W-1:0] rdata
);
    import lpfr_pkg::*;

    logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/lpfr_ctrl.sv =====
// Frame state machine: marker hunt, length gather, payload store, trailer check.
module lpfr_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [lpfr_pkg::BYTE_W-1:0] rx_byte,
    input  lpfr_pkg::marks_t            marks,
    output lpfr_pkg::evt_t              evt,
    output lpfr_pkg::buf_wr_t           wr
);
    import lpfr_pkg::*;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_CHECK  = 5'b01000,
        PH_END    = 5'b10000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              half_reg, half_next;
    logic [1:0]        len_cnt_reg, len_cnt_next;
    logic [31:0]       accum_reg, accum_next;
    logic [BUF_AW-1:0] pay_cnt_reg, pay_cnt_next;
    logic [CHK_W-1:0]  chk_cnt_reg, chk_cnt_next;
    logic [31:0]       accum_shift;
    logic [BUF_AW:0]   pay_cnt_inc;

    assign accum_shift = {accum_reg[23:0], rx_byte};
    assign pay_cnt_inc = {1'b0, pay_cnt_reg} + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        half_next    = half_reg;
        len_cnt_next = len_cnt_reg;
        accum_next   = accum_reg;
        pay_cnt_next = pay_cnt_reg;
        chk_cnt_next = chk_cnt_reg;
        evt.ev       = EV_NONE;
        evt.flen     = '0;
        wr.we        = 1'b0;
        wr.addr      = pay_cnt_reg;
        wr.data      = rx_byte;
        if (take)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (!half_reg)
                    begin
                        half_next = (rx_byte == marks.start_first);
                    end
                    else
                    begin
                        half_next = 1'b0;
                        if (rx_byte == marks.start_second)
                        begin
                            len_cnt_next = '0;
                            accum_next   = '0;
                            phase_next   = PH_LENGTH;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    accum_next   = accum_shift;
                    len_cnt_next = len_cnt_reg + 2'd1;
                    if (len_cnt_reg == 2'(LEN_BYTES - 1))
                    begin
                        if (accum_shift != '0 && accum_shift < 32'(MAX_PAYLOAD))
                        begin
                            pay_cnt_next = '0;
                            phase_next   = PH_DATA;
                        end
                        else
                        begin
                            evt.ev     = EV_BADLEN;
                            phase_next = PH_START;
                        end
                    end
                end
                PH_DATA:
                begin
                    wr.we        = 1'b1;
                    pay_cnt_next = pay_cnt_inc[BUF_AW-1:0];
                    if (pay_cnt_inc == accum_reg[BUF_AW:0])
                    begin
                        chk_cnt_next = '0;
                        phase_next   = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    chk_cnt_next = CHK_W'(chk_cnt_reg + 1'b1);
                    if (chk_cnt_reg == CHK_W'(CHECKSUM_BYTES - 1))
                    begin
                        half_next  = 1'b0;
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    if (!half_reg)
                    begin
                        half_next = (rx_byte == marks.end_first);
                    end
                    else
                    begin
                        half_next  = 1'b0;
                        phase_next = PH_START;
                        if (rx_byte == marks.end_second)
                        begin
                            evt.ev   = EV_ACCEPT;
                            evt.flen = accum_reg[FLEN_W-1:0];
                        end
                        else
                        begin
                            evt.ev = EV_BADEND;
                        end
                    end
                end
                default:
                begin
                    half_next  = 1'b0;
                    phase_next = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            half_reg    <= 1'b0;
            len_cnt_reg <= '0;
            accum_reg   <= '0;
            pay_cnt_reg <= '0;
            chk_cnt_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            half_reg    <= half_next;
            len_cnt_reg <= len_cnt_next;
            accum_reg   <= accum_next;
            pay_cnt_reg <= pay_cnt_next;
            chk_cnt_reg <= chk_cnt_next;
        end
    end

endmodule

// ===== rtl/core/lpfr_checker.sv =====
// Port-level checker for the length-prefixed frame receiver, with its bind.
module lpfr_port_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lpfr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [2:0]                     m_tuser
);
    import lpfr_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == EV_NONE || m_tuser == EV_ACCEPT || m_tuser == EV_BADLEN
                     || m_tuser == EV_BADEND || m_tuser == EV_READ)
        else $error("event code out of range");

    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_READ |-> m_tdata[BYTE_W-1:0] == '0)
        else $error("read data set on a non-read result");

    a_flen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_ACCEPT |-> m_tdata[BYTE_W +: FLEN_W] == '0)
        else $error("frame length set on a result other than frame accepted");

    a_len_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_ACCEPT |-> m_tdata[BYTE_W +: FLEN_W] != '0)
        else $error("accepted frame reports zero length");

endmodule

bind length_prefixed_frame_receiver lpfr_port_checker u_lpfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/lpfr_checker.sv =====
`timescale 1ns / 100ps
// Stream checker for the length-prefixed frame receiver: predicts and compares results.
module lpfr_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lpfr_pkg::S_TDATA_W-1:0] s_tdata,  // rx_byte[7:0], read_index[17:8]
    input  logic                           s_tuser,  // req_type
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lpfr_pkg::M_TDATA_W-1:0] m_tdata,  // read_data[7:0], frame_length[17:8]
    input  logic [2:0]                     m_tuser,  // event_res
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpfr_pkg::APB_AW-1:0]    paddr,
    input  logic [lpfr_pkg::APB_DW-1:0]    pwdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             outstanding,
    output logic [lpfr_pkg::BUF_AW:0]      filled
);
    import lpfr_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef enum logic [4:0] {
        HUNT_START    = 5'b00001,
        READ_LENGTH   = 5'b00010,
        STORE_PAYLOAD = 5'b00100,
        SKIP_CHECKSUM = 5'b01000,
        HUNT_END      = 5'b10000
    } rx_phase_t;

    typedef struct packed {
        event_t            ev;
        logic [BYTE_W-1:0] data;
        logic [FLEN_W-1:0] flen;
    } frame_result_t;

    marks_t            marks;
    rx_phase_t         phase;
    logic              half_seen;
    int                len_bytes;
    logic [31:0]       len_acc;
    int                pay_cnt;
    int                chk_cnt;
    logic [BYTE_W-1:0] payload_copy [MAX_PAYLOAD];
    int                filled_cnt;
    int                errors;
    frame_result_t     pending_results [$];

    // Advances the receive state by one request and returns the result it causes.
    function automatic frame_result_t deframe_step(input logic rd, input logic [7:0] b,
                                                   input logic [INDEX_W-1:0] idx);
        frame_result_t r;
        r.ev   = EV_NONE;
        r.data = '0;
        r.flen = '0;
        if (rd)
        begin
            r.ev = EV_READ;
            if (idx < MAX_PAYLOAD)
                r.data = payload_copy[idx];
            return r;
        end
        case (phase)
            HUNT_START:
            begin
                if (!half_seen)
                    half_seen = (b == marks.start_first);
                else
                begin
                    // The byte after a first marker byte is never taken as a new first byte.
                    half_seen = 1'b0;
                    if (b == marks.start_second)
                    begin
                        len_bytes = 0;
                        len_acc   = '0;
                        phase     = READ_LENGTH;
                    end
                end
            end
            READ_LENGTH:
            begin
                len_acc = {len_acc[23:0], b};
                len_bytes++;
                if (len_bytes >= LEN_BYTES)
                begin
                    if (len_acc != 0 && len_acc < MAX_PAYLOAD)
                    begin
                        pay_cnt = 0;
                        phase   = STORE_PAYLOAD;
                    end
                    else
                    begin
                        r.ev  = EV_BADLEN;
                        phase = HUNT_START;
                    end
                end
            end
            STORE_PAYLOAD:
            begin
                if (pay_cnt < MAX_PAYLOAD)
                begin
                    payload_copy[pay_cnt] = b;
                    if (pay_cnt >= filled_cnt)
                        filled_cnt = pay_cnt + 1;
                end
                pay_cnt++;
                if (pay_cnt >= len_acc)
                begin
                    chk_cnt = 0;
                    phase   = SKIP_CHECKSUM;
                end
            end
            SKIP_CHECKSUM:
            begin
                chk_cnt++;
                if (chk_cnt >= CHECKSUM_BYTES)
                begin
                    half_seen = 1'b0;
                    phase     = HUNT_END;
                end
            end
            HUNT_END:
            begin
                if (!half_seen)
                    half_seen = (b == marks.end_first);
                else
                begin
                    half_seen = 1'b0;
                    phase     = HUNT_START;
                    if (b == marks.end_second)
                    begin
                        r.ev   = EV_ACCEPT;
                        r.flen = len_acc[FLEN_W-1:0];
                    end
                    else
                        r.ev = EV_BADEND;
                end
            end
            default:
            begin
                half_seen = 1'b0;
                phase     = HUNT_START;
            end
        endcase
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t want;
        frame_result_t got;
        if (!rst_n)
        begin
            marks      = '0;
            phase      = HUNT_START;
            half_seen  = 1'b0;
            len_bytes  = 0;
            len_acc    = '0;
            pay_cnt    = 0;
            chk_cnt    = 0;
            filled_cnt = 0;
            errors     = 0;
            pending_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_START_FIRST:  marks.start_first  = pwdata[BYTE_W-1:0];
                    REG_START_SECOND: marks.start_second = pwdata[BYTE_W-1:0];
                    REG_END_FIRST:    marks.end_first    = pwdata[BYTE_W-1:0];
                    REG_END_SECOND:   marks.end_second   = pwdata[BYTE_W-1:0];
                    default:          marks = marks;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(deframe_step(s_tuser, s_tdata[7:0], s_tdata[17:8]));
            if (m_tvalid && m_tready)
            begin
                got.ev   = event_t'(m_tuser);
                got.data = m_tdata[7:0];
                got.flen = m_tdata[17:8];
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, got event %0d",
                                 $time, got.ev);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.ev !== want.ev)
                        note_mismatch("event_res", want.ev, got.ev);
                    if (got.data !== want.data)
                        note_mismatch("read_data", want.data, got.data);
                    if (got.flen !== want.flen)
                        note_mismatch("frame_length", want.flen, got.flen);
                end
            end
        end
        fail_count  <= errors;
        outstanding <= pending_results.size();
        filled      <= (BUF_AW + 1)'(filled_cnt);
    end

endmodule

// ===== test/length_prefixed_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the length-prefixed frame receiver: stimulus, idling and verdict.
module length_prefixed_frame_receiver_tb;

    import lpfr_pkg::*;

    // Results pass the middle stage and the output register, so DRAIN_CYCLES of quiet
    // after the last result are enough before touching the registers.
    localparam int DRAIN_CYCLES = 4;
    // Long enough for the output register and middle stage to fill and stall s_tready.
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 90;
    localparam int LONG_PAYLOAD = 300;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // rx_byte[7:0], read_index[17:8]
    logic                 s_tuser  = 1'b0;  // req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // read_data[7:0], frame_length[17:8]
    logic [2:0]           m_tuser;          // event_res
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int                   fail_count;
    int                   outstanding;
    logic [BUF_AW:0]      filled;

    // Marker bytes as last written, used to build well-formed frames.
    marks_t               cur_marks = '0;
    // Both sides stop idling while this is set.
    bit                   no_idle = 1'b0;
    // Asks the receiver for its one long hold-off.
    bit                   hold_off_go = 1'b0;
    int                   sent_count = 0;

    length_prefixed_frame_receiver uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lpfr_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .filled      (filled)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Safety net: a lost or stuck transaction ends the run here.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver side. It stalls in about a third of the cycles, never while no_idle
    // is set, and once holds off for HOLD_CYCLES while the sender keeps offering,
    // so the block's internal stages fill and the input stalls.
    initial
    begin
        bit hold_done;
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    // One register write: setup phase, access phase until pready, then a return to idle.
    task automatic write_mark(input reg_idx_t r, input logic [BYTE_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_START_FIRST:  cur_marks.start_first  = v;
            REG_START_SECOND: cur_marks.start_second = v;
            REG_END_FIRST:    cur_marks.end_first    = v;
            REG_END_SECOND:   cur_marks.end_second   = v;
            default:          cur_marks = cur_marks;
        endcase
        @(posedge clk);
    endtask

    task automatic set_marks(input logic [7:0] sf, input logic [7:0] ss,
                             input logic [7:0] ef, input logic [7:0] es);
        write_mark(REG_START_FIRST, sf);
        write_mark(REG_START_SECOND, ss);
        write_mark(REG_END_FIRST, ef);
        write_mark(REG_END_SECOND, es);
    endtask

    // Offers one request and returns at the clock edge that accepts it. An idle gap
    // precedes about a third of the transactions, but none while no_idle is set.
    task automatic offer(input logic user, input logic [17:0] fields);
        if (!no_idle && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= S_TDATA_W'(fields);
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    // The unused read_index bits are randomized too; the block must ignore them.
    task automatic send_byte(input logic [7:0] b);
        offer(1'b0, {10'($urandom), b});
    endtask

    // Reads only entries that some frame has already stored. The checker's count
    // may lag one transaction behind, which only makes the choice more cautious.
    task automatic send_read();
        if (filled == 0)
            return;
        offer(1'b1, {10'($urandom_range(0, filled - 1)), 8'($urandom)});
    endtask

    // A frame with a valid length. Only the first keep payload bytes go out when
    // keep is below len, which leaves the block waiting inside the payload.
    task automatic send_frame(input int len, input bit good_end, input int keep);
        logic [7:0] b;
        send_byte(cur_marks.start_first);
        send_byte(cur_marks.start_second);
        for (int k = 3; k >= 0; k--)
            send_byte(8'(len >> (8 * k)));
        for (int i = 0; i < keep; i++)
        begin
            send_byte(8'($urandom));
            if ($urandom_range(0, 99) < 8)
                send_read();
        end
        if (keep < len)
            return;
        repeat (CHECKSUM_BYTES) send_byte(8'($urandom));
        // Bytes other than the first end marker byte are skipped while waiting.
        repeat ($urandom_range(0, 2))
        begin
            do b = 8'($urandom); while (b == cur_marks.end_first);
            send_byte(b);
        end
        send_byte(cur_marks.end_first);
        if (good_end)
            send_byte(cur_marks.end_second);
        else
        begin
            do b = 8'($urandom); while (b == cur_marks.end_second);
            send_byte(b);
        end
    endtask

    // A header whose length is zero or too large for the buffer.
    task automatic send_bad_header();
        logic [31:0] len;
        case ($urandom_range(0, 3))
            0:       len = '0;
            1:       len = MAX_PAYLOAD;
            2:       len = '1;
            default: len = $urandom | MAX_PAYLOAD;
        endcase
        send_byte(cur_marks.start_first);
        send_byte(cur_marks.start_second);
        for (int k = 3; k >= 0; k--)
            send_byte(8'(len >> (8 * k)));
    endtask

    // Mostly frames with short payloads, some with a bad end marker, plus rejected headers,
    // loose bytes and reads, and frames cut off inside the payload.
    task automatic random_traffic(input int count);
        int first;
        int r;
        int len;
        first = sent_count;
        while (sent_count - first < count)
        begin
            r   = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 100) : $urandom_range(1, 8);
            if (r < 65)
                send_frame(len, $urandom_range(0, 3) != 0, len);
            else if (r < 75)
                send_bad_header();
            else if (r < 90)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_read();
                    else
                        send_byte(8'($urandom));
                end
            end
            else
                send_frame(len + 1, 1'b1, $urandom_range(0, len));
        end
    endtask

    // Stops offering and waits until every expected result has arrived, then lets
    // the pipeline run empty. The first edge lets the checker count the last request.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_marks(8'hA5, 8'h5A, 8'hC3, 8'h3C);

        // A first marker byte followed by another one clears the hunt, so the
        // second marker byte after it must not open a frame.
        send_byte(8'hA5);
        send_byte(8'hA5);
        send_byte(8'h5A);
        // A zero length is rejected.
        send_byte(8'hA5);
        send_byte(8'h5A);
        repeat (4) send_byte(8'h00);
        // One-byte frame, read back while the checksum is still coming in, with a
        // stray byte before the end marker.
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_read();
        repeat (CHECKSUM_BYTES - 1) send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hC3);
        send_byte(8'h3C);

        // A long payload; the receiver's long hold-off begins as this frame starts.
        hold_off_go = 1'b1;
        send_frame(LONG_PAYLOAD, 1'b1, LONG_PAYLOAD);
        random_traffic(PHASE_ITEMS);
        settle();

        set_marks(8'h00, 8'hFF, 8'hFF, 8'h00);
        random_traffic(PHASE_ITEMS);
        settle();

        // Equal start marker bytes, and a stretch where neither side idles.
        set_marks(8'hFF, 8'hFF, 8'h00, 8'h00);
        no_idle = 1'b1;
        random_traffic(PHASE_ITEMS);
        no_idle = 1'b0;
        settle();

        set_marks(8'h00, 8'h00, 8'h00, 8'h00);
        random_traffic(PHASE_ITEMS);
        settle();

        set_marks(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_traffic(PHASE_ITEMS);
        settle();

        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_regs.sv
rtl/core/lpfr_buf.sv
rtl/core/lpfr_ctrl.sv
rtl/core/length_prefixed_frame_receiver.sv
rtl/core/lpfr_checker.sv
test/lpfr_checker.sv
test/length_prefixed_frame_receiver_tb.sv
